>>> hdl/machine_mode_csr_unit_with_trap_entry_defines.svh
// ----------------------------------------------------------------------------
// Machine-mode CSR unit: assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef MACHINE_MODE_CSR_UNIT_WITH_TRAP_ENTRY_DEFINES_SVH
`define MACHINE_MODE_CSR_UNIT_WITH_TRAP_ENTRY_DEFINES_SVH

// clocked on clk, off while rst_n is low
`define MCSR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked on clk, checked during reset too
`define MCSR_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/mcsr_pkg.sv
// ----------------------------------------------------------------------------
// mcsr_pkg
// Types and constants shared by the machine-mode CSR unit.
// ----------------------------------------------------------------------------
package mcsr_pkg;

    localparam int unsigned XLEN      = 64;
    localparam int unsigned S_TDATA_W = 272;  // 270 bits of fields, byte padded
    localparam int unsigned M_TDATA_W = 136;  // 133 bits of fields, byte padded

    // commands
    localparam logic [2:0] CMD_READ     = 3'd0;
    localparam logic [2:0] CMD_WRITE    = 3'd1;
    localparam logic [2:0] CMD_TRAP     = 3'd2;
    localparam logic [2:0] CMD_SET_PC   = 3'd3;
    localparam logic [2:0] CMD_SET_PRIV = 3'd4;

    // error codes
    localparam logic [1:0] ERR_OK     = 2'd0;
    localparam logic [1:0] ERR_HARTID = 2'd1;
    localparam logic [1:0] ERR_UNSUP  = 2'd2;

    // configuration register indexes
    localparam logic CFG_STATUS_MASK = 1'b0;
    localparam logic CFG_START_PC    = 1'b1;

    // CSR addresses
    localparam logic [11:0] CSR_FFLAGS   = 12'h001;
    localparam logic [11:0] CSR_FRM      = 12'h002;
    localparam logic [11:0] CSR_FCSR     = 12'h003;
    localparam logic [11:0] CSR_MSTATUS  = 12'h300;
    localparam logic [11:0] CSR_MIE      = 12'h304;
    localparam logic [11:0] CSR_MTVEC    = 12'h305;
    localparam logic [11:0] CSR_MSCRATCH = 12'h340;
    localparam logic [11:0] CSR_MEPC     = 12'h341;
    localparam logic [11:0] CSR_MCAUSE   = 12'h342;
    localparam logic [11:0] CSR_MTVAL    = 12'h343;
    localparam logic [11:0] CSR_PMPCFG0  = 12'h3A0;
    localparam logic [11:0] CSR_PMPADDR0 = 12'h3B0;
    localparam logic [11:0] CSR_MHARTID  = 12'hF14;

    // mstatus bit positions
    localparam int unsigned MS_MIE    = 3;
    localparam int unsigned MS_MPIE   = 7;
    localparam int unsigned MS_MPP_LO = 11;
    localparam int unsigned MS_FS_LO  = 13;
    localparam int unsigned MS_SD     = 63;

    localparam logic [1:0] PRIV_M = 2'b11;

    localparam logic [XLEN-1:0] STATUS_MASK_RESET = 64'h0000_0000_0000_7888;
    localparam logic [XLEN-1:0] START_PC_RESET    = 64'h0;
    localparam logic [XLEN-1:0] MSTATUS_RESET     = 64'h0000_0002_0000_0000; // UXL = RV64

    typedef struct packed {
        logic [2:0]      cmd;
        logic [11:0]     csr_addr;
        logic [XLEN-1:0] write_data;
        logic [XLEN-1:0] trap_cause;
        logic [XLEN-1:0] trap_value;
        logic [XLEN-1:0] next_pc;
        logic [1:0]      next_priv;
    } item_t;

    typedef struct packed {
        logic [XLEN-1:0] read_data;
        logic            csr_exists;
        logic [1:0]      error_code;
        logic [XLEN-1:0] pc_now;
        logic [1:0]      priv_now;
    } result_t;

endpackage

>>> hdl/machine_mode_csr_unit_with_trap_entry.sv
// ----------------------------------------------------------------------------
// machine_mode_csr_unit_with_trap_entry
// RV64 machine-mode CSR file with pc, privilege level and trap entry.
//
//   channel   direction  signals                          fields
//   s_*       in         s_tvalid s_tready s_tdata s_tuser  one command item
//   m_*       out        m_tvalid m_tready m_tdata          one result item
//   cfg_*     in         cfg_wr_en cfg_index cfg_wdata      mask, boot pc
//
// One item per cycle sustained while m_tready stays high; an accepted item is
// held in the input register, then passes through the CSR update into the
// result register, where it becomes valid.
// The rate is set by the state update loop in mcsr_core.
// Reset empties both stages and loads all CSRs, pc and privilege.
// A stalled result holds the result register; the input stage then fills and
// s_tready drops until m_tready returns.
// ----------------------------------------------------------------------------
module machine_mode_csr_unit_with_trap_entry (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // csr_addr, write_data, trap_cause, trap_value, next_pc, next_priv, pad
    input  logic [mcsr_pkg::S_TDATA_W-1:0]  s_tdata,
    // cmd
    input  logic [2:0]                      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // read_data, csr_exists, error_code, pc_now, priv_now, pad
    output logic [mcsr_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic                            cfg_wr_en,
    input  logic                            cfg_index,
    input  logic [mcsr_pkg::XLEN-1:0]       cfg_wdata
);

    logic                          in_valid_reg;
    mcsr_pkg::item_t               in_item_reg;
    mcsr_pkg::item_t               item_next;
    logic                          out_valid_reg;
    logic [mcsr_pkg::M_TDATA_W-1:0] out_data_reg;
    mcsr_pkg::result_t             res;
    logic                          advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_comb
    begin
        item_next.cmd        = s_tuser;
        item_next.csr_addr   = s_tdata[11:0];
        item_next.write_data = s_tdata[75:12];
        item_next.trap_cause = s_tdata[139:76];
        item_next.trap_value = s_tdata[203:140];
        item_next.next_pc    = s_tdata[267:204];
        item_next.next_priv  = s_tdata[269:268];
    end

    mcsr_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .exec_en   (advance),
        .item      (in_item_reg),
        .result    (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            in_item_reg <= item_next;
        if (advance)
            out_data_reg <= {3'b000, res.priv_now, res.pc_now, res.error_code,
                             res.csr_exists, res.read_data};
    end

endmodule

>>> hdl/mcsr_core.sv
// ----------------------------------------------------------------------------
// mcsr_core
// CSR state, pc and privilege, with the one-pass update for one item.
// ----------------------------------------------------------------------------
module mcsr_core (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_wr_en,
    input  logic                    cfg_index,
    input  logic [mcsr_pkg::XLEN-1:0] cfg_wdata,
    input  logic                    exec_en,
    input  mcsr_pkg::item_t         item,
    output mcsr_pkg::result_t       result
);

    logic [63:0] mask_reg;
    logic [63:0] pc_reg, pc_next;
    logic [1:0]  priv_reg, priv_next;
    logic [7:0]  fcsr_reg, fcsr_next;
    logic [63:0] mstatus_reg, mstatus_next;
    logic [63:0] mie_reg, mie_next;
    logic [63:0] mtvec_reg, mtvec_next;
    logic [63:0] mscratch_reg, mscratch_next;
    logic [63:0] mepc_reg, mepc_next;
    logic [63:0] mcause_reg, mcause_next;
    logic [63:0] mtval_reg, mtval_next;
    logic [63:0] pmpcfg0_reg, pmpcfg0_next;
    logic [63:0] pmpaddr0_reg, pmpaddr0_next;

    logic        known;
    logic [63:0] rd_val;
    logic [63:0] wr_status;
    logic [63:0] trap_status;

    function automatic logic [63:0] with_sd(input logic [63:0] s);
        logic [63:0] r;
        r = s;
        r[mcsr_pkg::MS_SD] = (s[mcsr_pkg::MS_FS_LO +: 2] == 2'b11);
        return r;
    endfunction

    always_comb
    begin
        case (item.csr_addr)
            mcsr_pkg::CSR_FFLAGS, mcsr_pkg::CSR_FRM, mcsr_pkg::CSR_FCSR,
            mcsr_pkg::CSR_MSTATUS, mcsr_pkg::CSR_MHARTID, mcsr_pkg::CSR_MIE,
            mcsr_pkg::CSR_MTVEC, mcsr_pkg::CSR_MSCRATCH, mcsr_pkg::CSR_MEPC,
            mcsr_pkg::CSR_MCAUSE, mcsr_pkg::CSR_MTVAL, mcsr_pkg::CSR_PMPCFG0,
            mcsr_pkg::CSR_PMPADDR0: known = 1'b1;
            default:                known = 1'b0;
        endcase

        case (item.csr_addr)
            mcsr_pkg::CSR_FFLAGS:   rd_val = {59'd0, fcsr_reg[4:0]};
            mcsr_pkg::CSR_FRM:      rd_val = {61'd0, fcsr_reg[7:5]};
            mcsr_pkg::CSR_FCSR:     rd_val = {56'd0, fcsr_reg};
            mcsr_pkg::CSR_MSTATUS:  rd_val = mstatus_reg;
            mcsr_pkg::CSR_MIE:      rd_val = mie_reg;
            mcsr_pkg::CSR_MTVEC:    rd_val = mtvec_reg;
            mcsr_pkg::CSR_MSCRATCH: rd_val = mscratch_reg;
            mcsr_pkg::CSR_MEPC:     rd_val = mepc_reg;
            mcsr_pkg::CSR_MCAUSE:   rd_val = mcause_reg;
            mcsr_pkg::CSR_MTVAL:    rd_val = mtval_reg;
            mcsr_pkg::CSR_PMPCFG0:  rd_val = pmpcfg0_reg;
            mcsr_pkg::CSR_PMPADDR0: rd_val = pmpaddr0_reg;
            default:                rd_val = 64'd0;  // mhartid and unknown CSRs
        endcase

        wr_status = with_sd((mstatus_reg & ~mask_reg) | (item.write_data & mask_reg));

        // trap ignores the write mask
        trap_status                           = mstatus_reg;
        trap_status[mcsr_pkg::MS_MPIE]        = mstatus_reg[mcsr_pkg::MS_MIE];
        trap_status[mcsr_pkg::MS_MIE]         = 1'b0;
        trap_status[mcsr_pkg::MS_MPP_LO +: 2] = priv_reg;
        trap_status                           = with_sd(trap_status);

        pc_next       = pc_reg;
        priv_next     = priv_reg;
        fcsr_next     = fcsr_reg;
        mstatus_next  = mstatus_reg;
        mie_next      = mie_reg;
        mtvec_next    = mtvec_reg;
        mscratch_next = mscratch_reg;
        mepc_next     = mepc_reg;
        mcause_next   = mcause_reg;
        mtval_next    = mtval_reg;
        pmpcfg0_next  = pmpcfg0_reg;
        pmpaddr0_next = pmpaddr0_reg;

        result.read_data  = 64'd0;
        result.csr_exists = 1'b0;
        result.error_code = mcsr_pkg::ERR_OK;

        case (item.cmd)
            mcsr_pkg::CMD_READ:
            begin
                result.csr_exists = known;
                result.read_data  = rd_val;
            end
            mcsr_pkg::CMD_WRITE:
            begin
                result.csr_exists = known;
                case (item.csr_addr)
                    mcsr_pkg::CSR_FFLAGS:
                    begin
                        fcsr_next        = {fcsr_reg[7:5], item.write_data[4:0]};
                        result.read_data = {59'd0, item.write_data[4:0]};
                    end
                    mcsr_pkg::CSR_FRM:
                    begin
                        fcsr_next        = {item.write_data[2:0], fcsr_reg[4:0]};
                        result.read_data = {61'd0, item.write_data[2:0]};
                    end
                    mcsr_pkg::CSR_FCSR:
                    begin
                        fcsr_next        = item.write_data[7:0];
                        result.read_data = {56'd0, item.write_data[7:0]};
                    end
                    mcsr_pkg::CSR_MSTATUS:
                    begin
                        mstatus_next     = wr_status;
                        result.read_data = wr_status;
                    end
                    mcsr_pkg::CSR_MHARTID:
                        result.error_code = mcsr_pkg::ERR_HARTID;
                    mcsr_pkg::CSR_MIE:
                    begin
                        mie_next         = item.write_data;
                        result.read_data = item.write_data;
                    end
                    mcsr_pkg::CSR_MTVEC:
                    begin
                        mtvec_next       = {item.write_data[63:2], 2'b00};
                        result.read_data = {item.write_data[63:2], 2'b00};
                    end
                    mcsr_pkg::CSR_MSCRATCH:
                    begin
                        mscratch_next    = item.write_data;
                        result.read_data = item.write_data;
                    end
                    mcsr_pkg::CSR_MEPC:
                    begin
                        mepc_next        = {item.write_data[63:2], 2'b00};
                        result.read_data = {item.write_data[63:2], 2'b00};
                    end
                    mcsr_pkg::CSR_MCAUSE:
                    begin
                        mcause_next      = item.write_data;
                        result.read_data = item.write_data;
                    end
                    mcsr_pkg::CSR_MTVAL:
                    begin
                        mtval_next       = item.write_data;
                        result.read_data = item.write_data;
                    end
                    mcsr_pkg::CSR_PMPCFG0:
                    begin
                        pmpcfg0_next     = item.write_data;
                        result.read_data = item.write_data;
                    end
                    mcsr_pkg::CSR_PMPADDR0:
                    begin
                        pmpaddr0_next    = item.write_data;
                        result.read_data = item.write_data;
                    end
                    default:
                        result.error_code = mcsr_pkg::ERR_UNSUP;
                endcase
            end
            mcsr_pkg::CMD_TRAP:
            begin
                mstatus_next = trap_status;
                mcause_next  = item.trap_cause;
                mtval_next   = item.trap_value;
                mepc_next    = {pc_reg[63:2], 2'b00};
                pc_next      = {mtvec_reg[63:2], 2'b00};
                priv_next    = mcsr_pkg::PRIV_M;
            end
            mcsr_pkg::CMD_SET_PC:
                pc_next = item.next_pc;
            mcsr_pkg::CMD_SET_PRIV:
                priv_next = item.next_priv;
            default:
            begin
                // unused codes leave everything alone
            end
        endcase

        result.pc_now   = pc_next;
        result.priv_now = priv_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg     <= mcsr_pkg::STATUS_MASK_RESET;
            pc_reg       <= mcsr_pkg::START_PC_RESET;
            priv_reg     <= mcsr_pkg::PRIV_M;
            fcsr_reg     <= 8'd0;
            mstatus_reg  <= mcsr_pkg::MSTATUS_RESET;
            mie_reg      <= 64'd0;
            mtvec_reg    <= 64'd0;
            mscratch_reg <= 64'd0;
            mepc_reg     <= 64'd0;
            mcause_reg   <= 64'd0;
            mtval_reg    <= 64'd0;
            pmpcfg0_reg  <= 64'd0;
            pmpaddr0_reg <= 64'd0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                mcsr_pkg::CFG_STATUS_MASK: mask_reg <= cfg_wdata;
                mcsr_pkg::CFG_START_PC:    pc_reg   <= cfg_wdata;  // boot pc loads pc now
                default:                   mask_reg <= mask_reg;
            endcase
        end
        else if (exec_en)
        begin
            pc_reg       <= pc_next;
            priv_reg     <= priv_next;
            fcsr_reg     <= fcsr_next;
            mstatus_reg  <= mstatus_next;
            mie_reg      <= mie_next;
            mtvec_reg    <= mtvec_next;
            mscratch_reg <= mscratch_next;
            mepc_reg     <= mepc_next;
            mcause_reg   <= mcause_next;
            mtval_reg    <= mtval_next;
            pmpcfg0_reg  <= pmpcfg0_next;
            pmpaddr0_reg <= pmpaddr0_next;
        end
    end

endmodule

>>> hdl/mcsr_checker.sv
// ----------------------------------------------------------------------------
// mcsr_checker
// Port-level checks on the result stream of the CSR unit.
// ----------------------------------------------------------------------------
`include "machine_mode_csr_unit_with_trap_entry_defines.svh"

module mcsr_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [mcsr_pkg::M_TDATA_W-1:0]  m_tdata
);

    // result layout: read_data 63:0, csr_exists 64, error_code 66:65
    logic [63:0] rdata;
    logic        exists;
    logic [1:0]  err;

    assign rdata  = m_tdata[63:0];
    assign exists = m_tdata[64];
    assign err    = m_tdata[66:65];

    `MCSR_ASSERT(a_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "data moved")
    `MCSR_ASSERT(a_err_data, m_tvalid && err != mcsr_pkg::ERR_OK |-> rdata == '0, "err data")
    `MCSR_ASSERT(a_hartid, m_tvalid && err == mcsr_pkg::ERR_HARTID |-> exists, "hartid absent")
    `MCSR_ASSERT(a_unsup, m_tvalid && err == mcsr_pkg::ERR_UNSUP |-> !exists, "unsup present")
    `MCSR_ASSERT_ALWAYS(a_pad_zero, m_tvalid |-> m_tdata[135:133] == 3'b000, "pad not zero")

endmodule

bind machine_mode_csr_unit_with_trap_entry mcsr_checker u_mcsr_checker (.*);

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: machine-mode CSR unit testbench
// Streams CSR read/write, trap, set-pc and set-privilege items into the unit.
// Idle gaps and result stalls are random. A local model of the CSR file, pc
// and privilege predicts every result item, and each result is checked field
// by field. The mask and boot pc registers are rewritten between phases.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mcsr_pkg::*;

    localparam logic [XLEN-1:0] ALL_ONES = {XLEN{1'b1}};
    localparam int unsigned RANDOM_PHASES = 5;
    localparam int unsigned ITEMS_PER_PHASE = 96;

    localparam logic [11:0] KNOWN_CSRS [13] = '{
        CSR_FFLAGS, CSR_FRM, CSR_FCSR, CSR_MSTATUS, CSR_MIE, CSR_MTVEC,
        CSR_MSCRATCH, CSR_MEPC, CSR_MCAUSE, CSR_MTVAL, CSR_PMPCFG0,
        CSR_PMPADDR0, CSR_MHARTID
    };
    localparam logic [11:0] BANKED_CSRS [8] = '{
        CSR_MIE, CSR_MTVEC, CSR_MSCRATCH, CSR_MEPC, CSR_MCAUSE, CSR_MTVAL,
        CSR_PMPCFG0, CSR_PMPADDR0
    };

    typedef struct {
        item_t       cmd_item;
        int unsigned gap;
        bit          drain_first;  // hold until every result is back
    } queued_cmd_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    // csr_addr, write_data, trap_cause, trap_value, next_pc, next_priv, pad
    logic [S_TDATA_W-1:0]   s_tdata = '0;
    // cmd
    logic [2:0]             s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    // read_data, csr_exists, error_code, pc_now, priv_now, pad
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   cfg_wr_en = 1'b0;
    logic                   cfg_index = 1'b0;
    logic [XLEN-1:0]        cfg_wdata = '0;

    // predicted state of the unit
    logic [XLEN-1:0] mask_q   = STATUS_MASK_RESET;
    logic [XLEN-1:0] pc_q     = START_PC_RESET;
    logic [1:0]      priv_q   = PRIV_M;
    logic [7:0]      fcsr_q   = '0;
    logic [XLEN-1:0] status_q = MSTATUS_RESET;
    logic [XLEN-1:0] mregs_q [logic [11:0]];

    queued_cmd_t command_queue[$];
    result_t     csr_results_due[$];
    item_t       cmd_on_bus;
    int unsigned gap_count = 0;
    int unsigned stall_left = 0;
    int unsigned rx_draw;
    int unsigned items_queued = 0;
    int unsigned items_sent = 0;
    int unsigned results_seen = 0;
    int unsigned traps_sent = 0;
    int unsigned writes_sent = 0;
    int unsigned error_count = 0;

    machine_mode_csr_unit_with_trap_entry dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic logic [XLEN-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [XLEN-1:0] with_dirty_sd(input logic [XLEN-1:0] s);
        s[MS_SD] = (s[MS_FS_LO +: 2] == 2'b11);
        return s;
    endfunction

    function automatic bit csr_implemented(input logic [11:0] a);
        return a == CSR_FFLAGS || a == CSR_FRM || a == CSR_FCSR || a == CSR_MSTATUS ||
               a == CSR_MHARTID || mregs_q.exists(a);
    endfunction

    // Advances the CSR file by one item and returns the result it produces.
    function automatic result_t apply_command(input item_t c);
        result_t         r;
        logic [XLEN-1:0] v;
        r = '0;
        case (c.cmd)
            CMD_READ:
            begin
                r.csr_exists = csr_implemented(c.csr_addr);
                case (c.csr_addr)
                    CSR_FFLAGS:  r.read_data = {59'b0, fcsr_q[4:0]};
                    CSR_FRM:     r.read_data = {61'b0, fcsr_q[7:5]};
                    CSR_FCSR:    r.read_data = {56'b0, fcsr_q};
                    CSR_MSTATUS: r.read_data = status_q;
                    CSR_MHARTID: r.read_data = '0;
                    default:
                        if (mregs_q.exists(c.csr_addr))
                            r.read_data = mregs_q[c.csr_addr];
                endcase
            end
            CMD_WRITE:
            begin
                r.csr_exists = csr_implemented(c.csr_addr);
                case (c.csr_addr)
                    CSR_FFLAGS:
                    begin
                        fcsr_q[4:0] = c.write_data[4:0];
                        r.read_data = {59'b0, fcsr_q[4:0]};
                    end
                    CSR_FRM:
                    begin
                        fcsr_q[7:5] = c.write_data[2:0];
                        r.read_data = {61'b0, fcsr_q[7:5]};
                    end
                    CSR_FCSR:
                    begin
                        fcsr_q = c.write_data[7:0];
                        r.read_data = {56'b0, fcsr_q};
                    end
                    CSR_MSTATUS:
                    begin
                        status_q = with_dirty_sd((status_q & ~mask_q) | (c.write_data & mask_q));
                        r.read_data = status_q;
                    end
                    CSR_MHARTID: r.error_code = ERR_HARTID;
                    default:
                        if (mregs_q.exists(c.csr_addr))
                        begin
                            v = c.write_data;
                            if (c.csr_addr == CSR_MEPC || c.csr_addr == CSR_MTVEC)
                                v[1:0] = 2'b00;
                            mregs_q[c.csr_addr] = v;
                            r.read_data = v;
                        end
                        else
                            r.error_code = ERR_UNSUP;
                endcase
            end
            CMD_TRAP:
            begin
                // trap fields are forced regardless of the write mask
                v = status_q;
                v[MS_MPIE] = v[MS_MIE];
                v[MS_MIE] = 1'b0;
                v[MS_MPP_LO +: 2] = priv_q;
                status_q = with_dirty_sd(v);
                mregs_q[CSR_MCAUSE] = c.trap_cause;
                mregs_q[CSR_MTVAL] = c.trap_value;
                mregs_q[CSR_MEPC] = {pc_q[XLEN-1:2], 2'b00};
                pc_q = {mregs_q[CSR_MTVEC][XLEN-1:2], 2'b00};
                priv_q = PRIV_M;
            end
            CMD_SET_PC:   pc_q = c.next_pc;
            CMD_SET_PRIV: priv_q = c.next_priv;
            default: ;
        endcase
        r.pc_now = pc_q;
        r.priv_now = priv_q;
        return r;
    endfunction

    function automatic item_t make_item(input logic [2:0] cmd, input logic [11:0] addr,
                                        input logic [XLEN-1:0] wdata,
                                        input logic [XLEN-1:0] cause,
                                        input logic [XLEN-1:0] tval,
                                        input logic [XLEN-1:0] npc,
                                        input logic [1:0] npriv);
        item_t it;
        it.cmd = cmd;
        it.csr_addr = addr;
        it.write_data = wdata;
        it.trap_cause = cause;
        it.trap_value = tval;
        it.next_pc = npc;
        it.next_priv = npriv;
        return it;
    endfunction

    function automatic logic [11:0] pick_addr();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 7)
            return KNOWN_CSRS[$urandom_range(0, 12)];
        else if (r == 7)
            return KNOWN_CSRS[$urandom_range(0, 12)] ^ (12'h1 << $urandom_range(0, 11));
        return 12'($urandom_range(0, 4095));
    endfunction

    function automatic logic [XLEN-1:0] pick_data();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        else if (r == 1)
            return ALL_ONES;
        return rand64();
    endfunction

    function automatic item_t random_item();
        item_t       it;
        int unsigned r;
        it = make_item(CMD_READ, pick_addr(), pick_data(), rand64(), rand64(),
                       rand64(), 2'($urandom_range(0, 3)));
        r = $urandom_range(0, 99);
        if (r < 35)
            it.cmd = CMD_READ;
        else if (r < 70)
            it.cmd = CMD_WRITE;
        else if (r < 80)
            it.cmd = CMD_TRAP;
        else if (r < 87)
            it.cmd = CMD_SET_PC;
        else if (r < 95)
            it.cmd = CMD_SET_PRIV;
        else
            it.cmd = 3'($urandom_range(5, 7));
        return it;
    endfunction

    function automatic void queue_cmd(input item_t it, input bit drain_first);
        queued_cmd_t q;
        q.cmd_item = it;
        // every third stretch of 40 items goes back to back
        q.gap = ((items_queued / 40) % 3 == 0) ? 0 : $urandom_range(0, 9);
        q.drain_first = drain_first;
        command_queue.push_back(q);
        items_queued++;
    endfunction

    // handler setup, trap from some privilege, then look at what was saved
    function automatic void queue_trap_sequence();
        item_t it;
        it = random_item();
        it.cmd = CMD_WRITE;
        it.csr_addr = CSR_MTVEC;
        queue_cmd(it, 1'b0);
        it = random_item();
        it.cmd = CMD_WRITE;
        it.csr_addr = CSR_MSTATUS;
        queue_cmd(it, 1'b0);
        it = random_item();
        it.cmd = CMD_SET_PRIV;
        queue_cmd(it, 1'b0);
        it = random_item();
        it.cmd = CMD_TRAP;
        queue_cmd(it, 1'b0);
        it = random_item();
        it.cmd = CMD_READ;
        it.csr_addr = KNOWN_CSRS[$urandom_range(3, 9)];
        queue_cmd(it, 1'b0);
    endfunction

    task automatic wait_idle();
        while (command_queue.size() != 0 || s_tvalid || csr_results_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_cfg(input logic idx, input logic [XLEN-1:0] value);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        if (idx == CFG_STATUS_MASK)
            mask_q = value;
        else
            pc_q = value;  // boot pc write also loads the pc
    endtask

    task automatic check_field(input string name, input logic [XLEN-1:0] want,
                               input logic [XLEN-1:0] got);
        if (want !== got)
        begin
            $error("%s: expected %h, got %h", name, want, got);
            error_count++;
        end
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            gap_count <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                csr_results_due.push_back(apply_command(cmd_on_bus));
                items_sent++;
                if (cmd_on_bus.cmd == CMD_TRAP)
                    traps_sent++;
                if (cmd_on_bus.cmd == CMD_WRITE)
                    writes_sent++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (command_queue.size() != 0 && gap_count >= command_queue[0].gap &&
                    !(command_queue[0].drain_first && csr_results_due.size() != 0))
                begin
                    cmd_on_bus = command_queue.pop_front().cmd_item;
                    s_tuser <= cmd_on_bus.cmd;
                    s_tdata <= {2'b00, cmd_on_bus.next_priv, cmd_on_bus.next_pc,
                                cmd_on_bus.trap_value, cmd_on_bus.trap_cause,
                                cmd_on_bus.write_data, cmd_on_bus.csr_addr};
                    s_tvalid <= 1'b1;
                    gap_count <= 0;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                    if (command_queue.size() != 0)
                        gap_count <= gap_count + 1;
                end
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                if (csr_results_due.size() == 0)
                begin
                    $error("result item arrived with none outstanding");
                    error_count++;
                end
                else
                begin
                    result_t want;
                    want = csr_results_due.pop_front();
                    check_field("read_data", want.read_data, m_tdata[63:0]);
                    check_field("csr_exists", XLEN'(want.csr_exists), XLEN'(m_tdata[64]));
                    check_field("error_code", XLEN'(want.error_code), XLEN'(m_tdata[66:65]));
                    check_field("pc_now", want.pc_now, m_tdata[130:67]);
                    check_field("priv_now", XLEN'(want.priv_now), XLEN'(m_tdata[132:131]));
                end
                // one stretch in three takes results without stalls
                rx_draw = ((results_seen / 40) % 3 == 2) ? 0 : $urandom_range(0, 9);
                if (rx_draw != 0)
                begin
                    m_tready <= 1'b0;
                    stall_left <= rx_draw - 1;
                end
            end
            else if (!m_tready)
            begin
                if (stall_left == 0)
                    m_tready <= 1'b1;
                else
                    stall_left <= stall_left - 1;
            end
        end
    end

    initial
    begin
        logic [XLEN-1:0] phase_mask [RANDOM_PHASES];
        logic [XLEN-1:0] phase_pc [RANDOM_PHASES];
        int unsigned     phase_start;

        foreach (BANKED_CSRS[i])
            mregs_q[BANKED_CSRS[i]] = '0;
        phase_mask = '{'0, ALL_ONES, STATUS_MASK_RESET, rand64(), rand64()};
        phase_pc = '{ALL_ONES, '0, rand64(), rand64(), ALL_ONES};

        @(posedge rst_n);
        repeat (2) @(posedge clk);

        // directed: reset values, views of fcsr, masks, errors, trap entry
        queue_cmd(make_item(CMD_READ, CSR_MSTATUS, '0, '0, '0, '0, 2'd0), 1'b0);
        queue_cmd(make_item(CMD_READ, CSR_MHARTID, '0, '0, '0, '0, 2'd0), 1'b0);
        queue_cmd(make_item(CMD_WRITE, CSR_MSTATUS, ALL_ONES, '0, '0, '0, 2'd0), 1'b0);
        queue_cmd(make_item(CMD_WRITE, CSR_FCSR, ALL_ONES, '0, '0, '0, 2'd0), 1'b0);
        queue_cmd(make_item(CMD_WRITE, CSR_FFLAGS, '0, '0, '0, '0, 2'd0), 1'b0);
        queue_cmd(make_item(CMD_READ, CSR_FRM, '0, '0, '0, '0, 2'd0), 1'b0);
        queue_cmd(make_item(CMD_WRITE, CSR_FRM, '0, '0, '0, '0, 2'd0), 1'b0);
        queue_cmd(make_item(CMD_WRITE, CSR_FFLAGS, ALL_ONES, '0, '0, '0, 2'd0), 1'b0);
        queue_cmd(make_item(CMD_READ, CSR_FCSR, '0, '0, '0, '0, 2'd0), 1'b0);
        queue_cmd(make_item(CMD_WRITE, CSR_MTVEC, ALL_ONES, '0, '0, '0, 2'd0), 1'b0);
        queue_cmd(make_item(CMD_WRITE, CSR_MEPC, ALL_ONES, '0, '0, '0, 2'd0), 1'b0);
        queue_cmd(make_item(CMD_WRITE, CSR_MHARTID, ALL_ONES, '0, '0, '0, 2'd0), 1'b0);
        queue_cmd(make_item(CMD_WRITE, 12'hFFF, ALL_ONES, '0, '0, '0, 2'd0), 1'b0);
        queue_cmd(make_item(CMD_READ, 12'h000, '0, '0, '0, '0, 2'd0), 1'b0);
        queue_cmd(make_item(CMD_SET_PRIV, CSR_MSTATUS, '0, '0, '0, '0, 2'd2), 1'b0);
        queue_cmd(make_item(CMD_SET_PC, CSR_MSTATUS, '0, '0, '0, ALL_ONES, 2'd0), 1'b0);
        queue_cmd(make_item(CMD_TRAP, CSR_MSTATUS, '0, ALL_ONES, ALL_ONES, '0, 2'd0), 1'b0);
        queue_cmd(make_item(CMD_READ, CSR_MEPC, '0, '0, '0, '0, 2'd0), 1'b0);
        queue_cmd(make_item(CMD_READ, CSR_MSTATUS, '0, '0, '0, '0, 2'd0), 1'b0);
        queue_cmd(make_item(CMD_SET_PRIV, CSR_MSTATUS, '0, '0, '0, '0, 2'd0), 1'b0);
        queue_cmd(make_item(CMD_WRITE, CSR_MSTATUS, '0, '0, '0, '0, 2'd0), 1'b0);
        queue_cmd(make_item(CMD_TRAP, CSR_MSTATUS, '0, '0, '0, '0, 2'd1), 1'b0);
        queue_cmd(make_item(3'd7, 12'hFFF, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, 2'd3),
                  1'b0);
        queue_cmd(make_item(3'd5, CSR_MSTATUS, '0, '0, '0, '0, 2'd0), 1'b0);
        wait_idle();

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            write_cfg(CFG_STATUS_MASK, phase_mask[p]);
            write_cfg(CFG_START_PC, phase_pc[p]);
            phase_start = items_queued;
            // the first item of each phase waits for the pipe to drain
            queue_cmd(random_item(), 1'b1);
            while (items_queued - phase_start < ITEMS_PER_PHASE)
            begin
                if ($urandom_range(0, 9) == 0)
                    queue_trap_sequence();
                else
                    queue_cmd(random_item(), $urandom_range(0, 49) == 0);
            end
            wait_idle();
        end

        $display("Ran %0d items (%0d CSR writes, %0d traps) over %0d mask/boot-pc settings;",
                 items_sent, writes_sent, traps_sent, RANDOM_PHASES + 1);
        $display("checked %0d result items against the predicted CSR state.", results_seen);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> files.f
+incdir+hdl
hdl/mcsr_pkg.sv
hdl/mcsr_core.sv
hdl/machine_mode_csr_unit_with_trap_entry.sv
hdl/mcsr_checker.sv
verif/tb_top.sv
